// ----- rtl/ipu_pkg.sv -----
// Shared types and constants of the integer property unit.
package ipu_pkg;

  // Operation codes as they arrive on the request port.
  localparam logic [2:0] OP_PARITY  = 3'd0;
  localparam logic [2:0] OP_PRIME   = 3'd1;
  localparam logic [2:0] OP_PALIN   = 3'd2;
  localparam logic [2:0] OP_SIGN    = 3'd3;
  localparam logic [2:0] OP_REVERSE = 3'd4;
  localparam logic [2:0] OP_DSUM    = 3'd5;

  // Sign class codes of the result.
  localparam logic [1:0] SC_POS  = 2'd0;
  localparam logic [1:0] SC_NEG  = 2'd1;
  localparam logic [1:0] SC_ZERO = 2'd2;

  // Depth of the queue between the front and the back.
  localparam int unsigned Q_DEPTH = 2;

  // Work class that the front assigns to a request.
  typedef enum logic [2:0] {
    K_PARITY,
    K_PRIME,
    K_PALIN,
    K_SIGN,
    K_REVERSE,
    K_DSUM,
    K_BAD
  } kind_e;

  // Classification that travels with the operand magnitude.
  typedef struct packed {
    kind_e kind;
    logic  neg;
    logic  zero;
    logic  even;
  } cls_t;

endpackage

// ----- rtl/ipu_front.sv -----
// Front end: accepts requests, decodes the operation and splits off sign and magnitude.
module ipu_front #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic [2:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         full_i,
  output logic                         push_o,
  output ipu_pkg::cls_t                cls_o,
  output logic [DATA_WIDTH-1:0]        mag_o
);

  logic neg;

  assign neg     = value_i[DATA_WIDTH-1];
  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

  // The most negative value maps onto itself, which is its correct unsigned magnitude.
  assign mag_o = neg ? (DATA_WIDTH'(0) - DATA_WIDTH'(value_i)) : DATA_WIDTH'(value_i);

  always_comb begin
    cls_o.neg  = neg;
    cls_o.zero = (value_i == '0);
    cls_o.even = !value_i[0];
    unique case (op_i)
      ipu_pkg::OP_PARITY:  cls_o.kind = ipu_pkg::K_PARITY;
      ipu_pkg::OP_PRIME:   cls_o.kind = ipu_pkg::K_PRIME;
      ipu_pkg::OP_PALIN:   cls_o.kind = ipu_pkg::K_PALIN;
      ipu_pkg::OP_SIGN:    cls_o.kind = ipu_pkg::K_SIGN;
      ipu_pkg::OP_REVERSE: cls_o.kind = ipu_pkg::K_REVERSE;
      ipu_pkg::OP_DSUM:    cls_o.kind = ipu_pkg::K_DSUM;
      default:             cls_o.kind = ipu_pkg::K_BAD;
    endcase
  end

endmodule

// ----- rtl/ipu_queue.sv -----
// Short first-in first-out queue between the front and the back.
module ipu_queue #(
  parameter int unsigned WIDTH = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (ipu_pkg::Q_DEPTH > 1) ? $clog2(ipu_pkg::Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ipu_pkg::Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [ipu_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CW'(ipu_pkg::Q_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(ipu_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(ipu_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/ipu_back.sv -----
// Back end: sequencer with a bit-serial divider for trial division, a divide-by-ten step
// for the digit operations, and the output register.
module ipu_back #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  output logic                         pop_o,
  input  ipu_pkg::cls_t                cls_i,
  input  logic [DATA_WIDTH-1:0]        mag_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic                         flag_o,
  output logic signed [DATA_WIDTH-1:0] number_out_o,
  output logic [1:0]                   sign_class_o,
  output logic                         bad_op_o
);

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned CW = $clog2(DATA_WIDTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_POST = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;
  localparam logic [2:0] S_DACC = 3'd6;

  logic [2:0]          state_q, state_d;
  ipu_pkg::kind_e      kind_q, kind_d;
  logic                neg_q, neg_d;
  logic [W-1:0]        orig_q, orig_d;
  logic [W-1:0]        n_q, n_d;
  logic [W-1:0]        d_q, d_d;
  logic [W-1:0]        rev_q, rev_d;
  logic [W-1:0]        sum_q, sum_d;
  logic [W-1:0]        rem_q, rem_d;
  logic [W-1:0]        quo_q, quo_d;
  logic [W-1:0]        dsr_q, dsr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                res_flag_q, res_flag_d;
  logic [W-1:0]        res_num_q, res_num_d;
  logic [1:0]          res_sc_q, res_sc_d;
  logic                res_bad_q, res_bad_d;
  logic                out_valid_q, out_valid_d;
  logic                out_flag_q;
  logic [W-1:0]        out_num_q;
  logic [1:0]          out_sc_q;
  logic                out_bad_q;
  logic                out_load;
  logic [W:0]          shifted;
  logic [W:0]          trial;
  logic [W-1:0]        rem_step;
  logic [W-1:0]        quo_step;
  logic [W-1:0]        rev_next;
  logic [W-1:0]        d_next;
  logic [W-1:0]        q_est;
  logic [W-1:0]        r_est;
  logic                r_over;
  logic [W-1:0]        digit;
  logic [W-1:0]        q_fix;

  // One restoring division step: shift in the next dividend bit and try to subtract.
  assign shifted = {rem_q, quo_q[W-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  assign rem_step = trial[W] ? shifted[W-1:0] : trial[W-1:0];
  assign quo_step = {quo_q[W-2:0], !trial[W]};

  // Quotient estimate of n / 10 from shifts and adds. It is never above the true quotient
  // and at most one below it, so the remainder estimate lies in 0 to 19.
  always_comb begin
    q_est = (n_q >> 1) + (n_q >> 2);
    q_est = q_est + (q_est >> 4);
    q_est = q_est + (q_est >> 8);
    q_est = q_est + (q_est >> 16);
    q_est = q_est + (q_est >> 32);
    q_est = q_est >> 3;
  end

  assign r_est  = n_q - ((quo_q << 3) + (quo_q << 1));
  assign r_over = (r_est > W'(9));
  assign digit  = r_over ? (r_est - W'(10)) : r_est;
  assign q_fix  = quo_q + W'(r_over);

  assign rev_next = (rev_q << 3) + (rev_q << 1) + digit;
  assign d_next   = d_q + 1'b1;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !stall_i);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    neg_d      = neg_q;
    orig_d     = orig_q;
    n_d        = n_q;
    d_d        = d_q;
    rev_d      = rev_q;
    sum_d      = sum_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dsr_d      = dsr_q;
    cnt_d      = cnt_q;
    res_flag_d = res_flag_q;
    res_num_d  = res_num_q;
    res_sc_d   = res_sc_q;
    res_bad_d  = res_bad_q;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          kind_d     = cls_i.kind;
          neg_d      = cls_i.neg;
          orig_d     = mag_i;
          n_d        = mag_i;
          d_d        = W'(2);
          rev_d      = '0;
          sum_d      = '0;
          rem_d      = '0;
          quo_d      = mag_i;
          cnt_d      = '0;
          res_flag_d = 1'b0;
          res_num_d  = '0;
          res_sc_d   = ipu_pkg::SC_POS;
          res_bad_d  = 1'b0;
          unique case (cls_i.kind)
            ipu_pkg::K_PARITY: begin
              res_flag_d = cls_i.even;
              state_d    = S_OUT;
            end
            ipu_pkg::K_SIGN: begin
              res_sc_d = cls_i.zero ? ipu_pkg::SC_ZERO :
                         (cls_i.neg ? ipu_pkg::SC_NEG : ipu_pkg::SC_POS);
              state_d  = S_OUT;
            end
            ipu_pkg::K_PRIME: begin
              dsr_d = W'(2);
              if (cls_i.neg || (mag_i[W-1:1] == '0)) begin
                state_d = S_OUT;
              end else begin
                state_d = S_DIV;
              end
            end
            ipu_pkg::K_PALIN, ipu_pkg::K_REVERSE, ipu_pkg::K_DSUM: begin
              state_d = cls_i.zero ? S_FIN : S_DIG;
            end
            default: begin
              res_bad_d = 1'b1;
              state_d   = S_OUT;
            end
          endcase
        end
      end

      S_DIV: begin
        rem_d = rem_step;
        quo_d = quo_step;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          state_d = S_POST;
        end
      end

      S_POST: begin
        rem_d = '0;
        cnt_d = '0;
        // Divisors past the square root cannot split the value any more.
        if (d_q > quo_q) begin
          res_flag_d = 1'b1;
          state_d    = S_OUT;
        end else if (rem_q == '0) begin
          res_flag_d = 1'b0;
          state_d    = S_OUT;
        end else begin
          d_d     = d_next;
          dsr_d   = d_next;
          quo_d   = n_q;
          state_d = S_DIV;
        end
      end

      S_DIG: begin
        quo_d   = q_est;
        state_d = S_DACC;
      end

      S_DACC: begin
        // Correct the estimate and fold the lowest digit into the reversal and the sum.
        rev_d   = rev_next;
        sum_d   = sum_q + digit;
        n_d     = q_fix;
        state_d = (q_fix == '0) ? S_FIN : S_DIG;
      end

      S_FIN: begin
        // Negation is a bijection, so the palindrome test can compare magnitudes.
        res_flag_d = (kind_q == ipu_pkg::K_PALIN) && (rev_q == orig_q);
        if (kind_q == ipu_pkg::K_REVERSE) begin
          res_num_d = neg_q ? (W'(0) - rev_q) : rev_q;
        end else if (kind_q == ipu_pkg::K_DSUM) begin
          res_num_d = neg_q ? (W'(0) - sum_q) : sum_q;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    neg_q      <= neg_d;
    orig_q     <= orig_d;
    n_q        <= n_d;
    d_q        <= d_d;
    rev_q      <= rev_d;
    sum_q      <= sum_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dsr_q      <= dsr_d;
    cnt_q      <= cnt_d;
    res_flag_q <= res_flag_d;
    res_num_q  <= res_num_d;
    res_sc_q   <= res_sc_d;
    res_bad_q  <= res_bad_d;
    if (out_load) begin
      out_flag_q <= res_flag_q;
      out_num_q  <= res_num_q;
      out_sc_q   <= res_sc_q;
      out_bad_q  <= res_bad_q;
    end
  end

  assign valid_o      = out_valid_q;
  assign flag_o       = out_flag_q;
  assign number_out_o = out_num_q;
  assign sign_class_o = out_sc_q;
  assign bad_op_o     = out_bad_q;

endmodule

// ----- rtl/integer_property_unit.sv -----
// Top level of the integer property unit: front end, request queue and back end.
//
// The unit examines one signed operand per request and answers with exactly one result:
// parity, a trial-division primality flag, a decimal palindrome flag, the sign class,
// the decimal digit reversal, or the digit sum, as the operation code selects. Codes 6
// and 7 set bad_op_o and leave every other result field at zero. Digits come from
// truncating division, so negative operands yield a negative reversal and digit sum,
// and a reversal that overflows wraps modulo 2^DATA_WIDTH. Requests are taken into a
// two-entry queue, so the front keeps accepting while the back is busy; the back works
// on one request at a time. Parity, sign and invalid codes go from the idle state
// straight to the output state. Digit operations divide by ten with a shift-and-add
// estimate and a one-step correction, each decimal digit passing through an estimate
// state and a correction state; a zero operand skips both. The primality test runs a
// bit-serial divider once per trial divisor, and divisors run from 2 up to the square
// root of the operand, so a large prime is the slowest request. A request that finds
// the back busy waits in the queue for the earlier ones. A result waits in the output
// register until it is taken.
module integer_property_unit #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         flag_o,
  output logic signed [DATA_WIDTH-1:0] number_out_o,
  output logic [1:0]                   sign_class_o,
  output logic                         bad_op_o
);

  // A queue entry carries the classification above the operand magnitude.
  localparam int unsigned QW = $bits(ipu_pkg::cls_t) + DATA_WIDTH;

  ipu_pkg::cls_t         front_cls;
  logic [DATA_WIDTH-1:0] front_mag;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  empty;
  logic [QW-1:0]         pop_data;
  ipu_pkg::cls_t         back_cls;
  logic [DATA_WIDTH-1:0] back_mag;

  // The front decodes the request and never waits on the back, only on a full queue.
  ipu_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .valid_i(in_valid_i),
    .stall_o(in_stall_o),
    .op_i   (op_i),
    .value_i(value_i),
    .full_i (full),
    .push_o (push),
    .cls_o  (front_cls),
    .mag_o  (front_mag)
  );

  ipu_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i({front_cls, front_mag}),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  assign back_cls = pop_data[QW-1:DATA_WIDTH];
  assign back_mag = pop_data[DATA_WIDTH-1:0];

  // The back pulls the next request only when it is idle and drives the result port.
  ipu_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_o       (pop),
    .cls_i       (back_cls),
    .mag_i       (back_mag),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .flag_o      (flag_o),
    .number_out_o(number_out_o),
    .sign_class_o(sign_class_o),
    .bad_op_o    (bad_op_o)
  );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench of the integer property unit: directed and random requests.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DW = 32;

  // Codes 6 and 7 are not operations; the unit must flag them.
  localparam logic [2:0] OP_INVALID_LO = 3'd6;
  localparam logic [2:0] OP_INVALID_HI = 3'd7;

  // Cycles without any accepted request or result before the run is abandoned. The
  // slowest request sent here is a prime test near 2^20.
  localparam int unsigned STALL_LIMIT = 200_000;

  // Cycles to wait after the last expected result, in case a stray result follows.
  localparam int unsigned TAIL_CYCLES = 100;

  // One result as the unit presents it on its output port.
  typedef struct packed {
    logic          flag;
    logic [DW-1:0] number;
    logic [1:0]    sign_class;
    logic          bad_op;
  } property_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           op_i = ipu_pkg::OP_PARITY;
  logic signed [DW-1:0] value_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 flag_o;
  logic signed [DW-1:0] number_out_o;
  logic [1:0]           sign_class_o;
  logic                 bad_op_o;

  // Results predicted for accepted requests, oldest first.
  property_result_t pending_properties[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  always #1 clk_i = ~clk_i;

  integer_property_unit #(
    .DATA_WIDTH(DW)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .flag_o      (flag_o),
    .number_out_o(number_out_o),
    .sign_class_o(sign_class_o),
    .bad_op_o    (bad_op_o)
  );

  // Decimal digit reversal of a magnitude, modulo 2^64.
  function automatic logic [63:0] reverse_digits(input logic [63:0] mag);
    logic [63:0] rev;
    rev = '0;
    while (mag != 0) begin
      rev = rev * 64'd10 + mag % 64'd10;
      mag = mag / 64'd10;
    end
    return rev;
  endfunction

  function automatic logic [63:0] sum_digits(input logic [63:0] mag);
    logic [63:0] total;
    total = '0;
    while (mag != 0) begin
      total = total + mag % 64'd10;
      mag = mag / 64'd10;
    end
    return total;
  endfunction

  // Trial division with divisors from 2 up to the square root.
  function automatic logic is_prime(input logic [DW-1:0] n);
    logic [63:0] divisor;
    if (n < 2) return 1'b0;
    for (divisor = 64'd2; divisor <= 64'(n) / divisor; divisor++) begin
      if (64'(n) % divisor == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected result of one request. Negative operands have their digits worked out on
  // the magnitude and then negated, which matches truncating division by ten.
  function automatic property_result_t predict_properties(input logic [2:0] op,
                                                          input logic [DW-1:0] v);
    property_result_t res;
    logic             neg;
    logic [DW-1:0]    mag;
    logic [63:0]      acc;
    res = '0;
    neg = v[DW-1];
    mag = neg ? (~v + 1'b1) : v;
    case (op)
      ipu_pkg::OP_PARITY: res.flag = ~v[0];
      ipu_pkg::OP_PRIME:  res.flag = !neg && is_prime(v);
      ipu_pkg::OP_PALIN: begin
        // The wrapped reversal is what gets compared with the operand.
        acc = reverse_digits(64'(mag));
        if (neg) acc = 64'd0 - acc;
        res.flag = (acc[DW-1:0] == v);
      end
      ipu_pkg::OP_SIGN: begin
        if (v == 0) res.sign_class = ipu_pkg::SC_ZERO;
        else if (neg) res.sign_class = ipu_pkg::SC_NEG;
        else res.sign_class = ipu_pkg::SC_POS;
      end
      ipu_pkg::OP_REVERSE: begin
        acc = reverse_digits(64'(mag));
        if (neg) acc = 64'd0 - acc;
        res.number = acc[DW-1:0];
      end
      ipu_pkg::OP_DSUM: begin
        acc = sum_digits(64'(mag));
        if (neg) acc = 64'd0 - acc;
        res.number = acc[DW-1:0];
      end
      default: res.bad_op = 1'b1;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] exp);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp);
    mismatch_count++;
  endtask

  // Sends one request. A random gap with valid low may come first; once valid is high it
  // stays high, with the payload held, until the unit takes the request.
  task automatic send_request(input logic [2:0] op, input logic [DW-1:0] value);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    value_i    <= value;
    do @(posedge clk_i); while (in_stall_o);
    pending_properties.push_back(predict_properties(op, value));
  endtask

  // Lowers valid and holds off until every outstanding result has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_properties.size() != 0) @(posedge clk_i);
  endtask

  // Operand for a random request. Prime tests use operands that finish quickly: small
  // values, negatives, numbers with a factor of 2 or 3, and a few up to 2^20.
  function automatic logic [DW-1:0] random_value(input logic [2:0] op);
    logic [DW-1:0] v;
    logic [63:0]   half;
    logic [63:0]   scale;
    logic [63:0]   rest;
    if (op == ipu_pkg::OP_PRIME) begin
      case ($urandom_range(0, 9))
        0:       v = {1'b1, 31'($urandom)};
        1:       v = $urandom & 32'h7FFF_FFFE;
        2:       v = 32'($urandom_range(0, 715827882)) * 32'd3;
        3:       v = $urandom_range(0, 1 << 20);
        default: v = $urandom_range(0, 4095);
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0, 1: v = 32'($urandom_range(0, 1998)) - 32'd999;
        2: begin
          case ($urandom_range(0, 4))
            0:       v = '0;
            1:       v = '1;
            2:       v = 32'd1;
            3:       v = 32'h8000_0000;
            default: v = 32'h7FFF_FFFF;
          endcase
        end
        3: begin
          // An even-length palindrome: digits followed by their mirror image.
          half  = 64'($urandom_range(1, 9999));
          scale = 64'd1;
          rest  = half;
          while (rest != 0) begin
            scale = scale * 64'd10;
            rest  = rest / 64'd10;
          end
          v = 32'(half * scale + reverse_digits(half));
          if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
        end
        default: v = $urandom;
      endcase
    end
    return v;
  endfunction

  // Receiver side: stall at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Every accepted result is compared with the oldest prediction, field by field.
  always @(posedge clk_i) begin
    property_result_t exp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_properties.size() == 0) begin
        report_mismatch("unexpected result, number_out", number_out_o, 0);
      end else begin
        exp = pending_properties.pop_front();
        if (flag_o !== exp.flag) report_mismatch("flag", flag_o, exp.flag);
        if (number_out_o !== exp.number)
          report_mismatch("number_out", number_out_o, $signed(exp.number));
        if (sign_class_o !== exp.sign_class)
          report_mismatch("sign_class", sign_class_o, exp.sign_class);
        if (bad_op_o !== exp.bad_op) report_mismatch("bad_op", bad_op_o, exp.bad_op);
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic test_parity();
    send_request(ipu_pkg::OP_PARITY, 32'h8000_0000);
    send_request(ipu_pkg::OP_PARITY, 32'h7FFF_FFFF);
  endtask

  // Values up to 1 and all negatives are not prime; the large even operand exits at the
  // first divisor.
  task automatic test_primality();
    send_request(ipu_pkg::OP_PRIME, 32'd1);
    send_request(ipu_pkg::OP_PRIME, 32'd2);
    send_request(ipu_pkg::OP_PRIME, 32'd9);
    send_request(ipu_pkg::OP_PRIME, -32'sd7);
    send_request(ipu_pkg::OP_PRIME, 32'd65521);
    send_request(ipu_pkg::OP_PRIME, 32'd2147483646);
  endtask

  // Zero is a palindrome; 1000000003 reverses past 2^31 and wraps.
  task automatic test_palindrome();
    send_request(ipu_pkg::OP_PALIN, 32'd0);
    send_request(ipu_pkg::OP_PALIN, 32'd12321);
    send_request(ipu_pkg::OP_PALIN, -32'sd121);
    send_request(ipu_pkg::OP_PALIN, 32'd123);
    send_request(ipu_pkg::OP_PALIN, 32'd1000000003);
  endtask

  task automatic test_sign_class();
    send_request(ipu_pkg::OP_SIGN, 32'd0);
    send_request(ipu_pkg::OP_SIGN, 32'd5);
    send_request(ipu_pkg::OP_SIGN, -32'sd5);
  endtask

  task automatic test_reversal();
    send_request(ipu_pkg::OP_REVERSE, 32'd0);
    send_request(ipu_pkg::OP_REVERSE, 32'd1000000003);
    send_request(ipu_pkg::OP_REVERSE, -32'sd123);
    send_request(ipu_pkg::OP_REVERSE, 32'h7FFF_FFFF);
  endtask

  task automatic test_digit_sum();
    send_request(ipu_pkg::OP_DSUM, 32'd0);
    send_request(ipu_pkg::OP_DSUM, 32'h7FFF_FFFF);
    send_request(ipu_pkg::OP_DSUM, 32'h8000_0000);
  endtask

  task automatic test_invalid_op();
    send_request(OP_INVALID_LO, 32'h1234_5678);
    send_request(OP_INVALID_HI, 32'hFFFF_FFFF);
  endtask

  // Random requests with the given idle and stall rates on the two sides.
  task automatic test_random_phase(input int unsigned count, input int unsigned idle,
                                   input int unsigned stall);
    logic [2:0] op;
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (count) begin
      op = 3'($urandom_range(0, 7));
      send_request(op, random_value(op));
    end
  endtask

  // The sender stops until every outstanding result is back, then resumes.
  task automatic test_drain_pause();
    logic [2:0] op;
    send_idle_pct = 0;
    stall_pct     = 50;
    repeat (6) begin
      op = 3'($urandom_range(0, 7));
      send_request(op, random_value(op));
    end
    wait_drained();
    repeat (6) begin
      op = 3'($urandom_range(0, 7));
      send_request(op, random_value(op));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_parity();
    test_primality();
    test_palindrome();
    test_sign_class();
    test_reversal();
    test_digit_sum();
    test_invalid_op();

    test_random_phase(75, 0, 0);
    test_random_phase(75, 81, 0);
    test_random_phase(75, 0, 81);
    test_random_phase(75, 22, 22);
    test_drain_pause();

    wait_drained();
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_properties.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
